>>> hdl/spfo_pkg.sv
// shared opcodes, constants and pipeline stage types of the single precision fpu
`default_nettype none

package spfo_pkg;

    // funct7 opcodes
    localparam logic [6:0] OP_ADD    = 7'b0000000;
    localparam logic [6:0] OP_SUB    = 7'b0000100;
    localparam logic [6:0] OP_MUL    = 7'b0001000;
    localparam logic [6:0] OP_SGN    = 7'b0010000;
    localparam logic [6:0] OP_MINMAX = 7'b0010100;
    localparam logic [6:0] OP_F2I    = 7'b1100000;
    localparam logic [6:0] OP_CMP    = 7'b1010000;
    localparam logic [6:0] OP_I2F    = 7'b1101000;

    // funct3 variants
    localparam logic [2:0] VAR_SGNJ  = 3'd0;
    localparam logic [2:0] VAR_SGNJN = 3'd1;
    localparam logic [2:0] VAR_SGNJX = 3'd2;
    localparam logic [2:0] VAR_MIN   = 3'd0;
    localparam logic [2:0] VAR_MAX   = 3'd1;
    localparam logic [2:0] VAR_FLE   = 3'd0;
    localparam logic [2:0] VAR_FLT   = 3'd1;
    localparam logic [2:0] VAR_FEQ   = 3'd2;

    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] ERR_CODE  = 32'hDEAD_BEEF;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef logic signed [9:0] exp_t;

    typedef struct packed {
        logic        fast;
        logic [31:0] res;
        logic        do_add;
        logic        eff_sub;
        logic        sign;
        logic        zsign;
        exp_t        exp;
        logic [47:0] x;
        logic [47:0] y;
    } s1_t;

    typedef struct packed {
        logic        fast;
        logic [31:0] res;
        logic        sign;
        logic        zsign;
        exp_t        exp;
        logic [47:0] mag;
    } s2_t;

    typedef struct packed {
        logic        fast;
        logic [31:0] res;
        logic        sign;
        logic        zsign;
        logic        zero;
        logic        denorm;
        logic        left;
        logic [5:0]  amt;
        exp_t        exp;
        logic [47:0] mag;
    } s3_t;

    typedef struct packed {
        logic        fast;
        logic [31:0] res;
        logic        sign;
        logic        zsign;
        logic        zero;
        logic        denorm;
        exp_t        exp;
        logic [47:0] mag;
    } s4_t;

endpackage

`default_nettype wire

>>> hdl/spfo_if.sv
// request and response channel interfaces
`default_nettype none

interface spfo_req_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cmd;
    logic [2:0]  variant;
    logic        unsigned_sel;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, cmd, variant, unsigned_sel, operand_a, operand_b,
                    input ready);
    modport sink   (input valid, cmd, variant, unsigned_sel, operand_a, operand_b,
                    output ready);
endinterface

interface spfo_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

>>> hdl/spfo_prep.sv
// first stage: decode, special cases, simple ops, add alignment and significand multiply
`default_nettype none

module spfo_prep (
    input  logic [6:0]     cmd,
    input  logic [2:0]     variant,
    input  logic           unsigned_sel,
    input  logic [31:0]    operand_a,
    input  logic [31:0]    operand_b,
    output spfo_pkg::s1_t  s1
);
    import spfo_pkg::*;

    logic        sa, sb, sb_eff;
    logic [7:0]  ea, eb, eae, ebe;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, both_zero, any_nan;
    logic        a_lt_mag, b_lt_mag;
    logic        lt_ab, lt_ba, eq_ab;

    // add alignment
    logic        swap, sx, sy;
    logic [7:0]  ex_e, ey_e, d;
    logic [23:0] mx, my;
    logic [47:0] y48, y_sh, y_al;
    logic        lost;

    // float to int
    logic [4:0]  e5;
    logic [54:0] f2i_wide;
    logic [31:0] f2i_mag, f2i_res;
    logic        f2i_big;

    // int to float
    logic        i2f_neg;
    logic [31:0] i2f_mag;

    logic [47:0] prod;

    assign sa = operand_a[31];
    assign sb = operand_b[31];
    assign ea = operand_a[30:23];
    assign eb = operand_b[30:23];
    assign fa = operand_a[22:0];
    assign fb = operand_b[22:0];
    assign ma = {ea != 8'd0, fa};
    assign mb = {eb != 8'd0, fb};
    assign eae = (ea == 8'd0) ? 8'd1 : ea;
    assign ebe = (eb == 8'd0) ? 8'd1 : eb;

    assign nan_a  = (ea == 8'hFF) && (fa != 23'd0);
    assign nan_b  = (eb == 8'hFF) && (fb != 23'd0);
    assign inf_a  = (ea == 8'hFF) && (fa == 23'd0);
    assign inf_b  = (eb == 8'hFF) && (fb == 23'd0);
    assign zero_a = operand_a[30:0] == 31'd0;
    assign zero_b = operand_b[30:0] == 31'd0;
    assign both_zero = zero_a && zero_b;
    assign any_nan   = nan_a || nan_b;

    assign a_lt_mag = operand_a[30:0] < operand_b[30:0];
    assign b_lt_mag = operand_b[30:0] < operand_a[30:0];

    assign lt_ab = !any_nan && !both_zero &&
                   ((sa && !sb) || (!sa && !sb && a_lt_mag) || (sa && sb && b_lt_mag));
    assign lt_ba = !any_nan && !both_zero &&
                   ((sb && !sa) || (!sa && !sb && b_lt_mag) || (sa && sb && a_lt_mag));
    assign eq_ab = !any_nan && ((operand_a == operand_b) || both_zero);

    // larger magnitude goes first so the difference never goes negative
    assign sb_eff = sb ^ (cmd == OP_SUB);
    assign swap   = a_lt_mag;
    assign sx     = swap ? sb_eff : sa;
    assign sy     = swap ? sa : sb_eff;
    assign ex_e   = swap ? ebe : eae;
    assign ey_e   = swap ? eae : ebe;
    assign mx     = swap ? mb : ma;
    assign my     = swap ? ma : mb;
    assign d      = ex_e - ey_e;
    assign y48    = {1'b0, my, 23'd0};
    assign y_sh   = y48 >> d[5:0];
    assign lost   = |(y48 & ~({48{1'b1}} << d[5:0]));
    assign y_al   = (d >= 8'd48) ? {47'd0, |my} : (y_sh | {47'd0, lost});

    // truncating conversion, shifts the significand into place
    assign e5       = 5'(ea - 8'd127);
    assign f2i_wide = {31'd0, 1'b1, fa} << e5;
    assign f2i_big  = ea >= 8'd159;
    assign f2i_mag  = (ea < 8'd127) ? 32'd0 : f2i_wide[54:23];

    always_comb
    begin
        if (nan_a)
            f2i_res = unsigned_sel ? 32'hFFFF_FFFF : MAG_MASK;
        else if (unsigned_sel)
            f2i_res = sa ? 32'd0 : (f2i_big ? 32'hFFFF_FFFF : f2i_mag);
        else if (sa)
            f2i_res = (f2i_big || (f2i_mag > SIGN_BIT)) ? SIGN_BIT : (32'd0 - f2i_mag);
        else
            f2i_res = (f2i_big || f2i_mag[31]) ? MAG_MASK : f2i_mag;
    end

    assign i2f_neg = !unsigned_sel && operand_a[31];
    assign i2f_mag = i2f_neg ? (32'd0 - operand_a) : operand_a;

    assign prod = ma * mb;

    always_comb
    begin
        s1 = '0;
        s1.fast = 1'b1;
        s1.res  = ERR_CODE;
        unique case (cmd) inside
            OP_ADD, OP_SUB:
            begin
                if (any_nan || (inf_a && inf_b && (sa != sb_eff)))
                    s1.res = CANON_NAN;
                else if (inf_a)
                    s1.res = {sa, 8'hFF, 23'd0};
                else if (inf_b)
                    s1.res = {sb_eff, 8'hFF, 23'd0};
                else
                begin
                    s1.fast    = 1'b0;
                    s1.do_add  = 1'b1;
                    s1.eff_sub = sx ^ sy;
                    s1.sign    = sx;
                    s1.zsign   = sa && sb_eff;
                    s1.exp     = exp_t'({2'b00, ex_e}) + 10'sd1;
                    s1.x       = {1'b0, mx, 23'd0};
                    s1.y       = y_al;
                end
            end
            OP_MUL:
            begin
                if (any_nan || (inf_a && zero_b) || (zero_a && inf_b))
                    s1.res = CANON_NAN;
                else if (inf_a || inf_b)
                    s1.res = {sa ^ sb, 8'hFF, 23'd0};
                else
                begin
                    s1.fast  = 1'b0;
                    s1.sign  = sa ^ sb;
                    s1.zsign = sa ^ sb;
                    s1.exp   = exp_t'({2'b00, eae}) + exp_t'({2'b00, ebe}) - 10'sd126;
                    s1.x     = prod;
                end
            end
            OP_SGN:
            begin
                unique case (variant)
                    VAR_SGNJ:  s1.res = {sb, operand_a[30:0]};
                    VAR_SGNJN: s1.res = {!sb, operand_a[30:0]};
                    VAR_SGNJX: s1.res = {sa ^ sb, operand_a[30:0]};
                    default:   s1.res = ERR_CODE;
                endcase
            end
            OP_MINMAX:
            begin
                unique case (variant)
                    VAR_MIN: s1.res = lt_ba ? operand_b : operand_a;
                    VAR_MAX: s1.res = lt_ab ? operand_b : operand_a;
                    default: s1.res = ERR_CODE;
                endcase
            end
            OP_CMP:
            begin
                unique case (variant)
                    VAR_FEQ: s1.res = {31'd0, eq_ab};
                    VAR_FLT: s1.res = {31'd0, lt_ab};
                    VAR_FLE: s1.res = {31'd0, lt_ab || eq_ab};
                    default: s1.res = ERR_CODE;
                endcase
            end
            OP_F2I:
                s1.res = f2i_res;
            OP_I2F:
            begin
                // integer sits at the top so bit 47 weighs 2^31
                s1.fast  = 1'b0;
                s1.sign  = i2f_neg;
                s1.zsign = 1'b0;
                s1.exp   = 10'sd158;
                s1.x     = {i2f_mag, 16'd0};
            end
            default:
                s1.res = ERR_CODE;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/spfo_round.sv
// last stage: round to nearest even and pack the single precision result
`default_nettype none

module spfo_round (
    input  spfo_pkg::s4_t s4,
    output logic [31:0]   result
);
    import spfo_pkg::*;

    logic [23:0] kept;
    logic        guard, sticky, up;
    logic [24:0] r;
    exp_t        exp_fin;
    logic [22:0] mant;

    assign kept   = s4.mag[47:24];
    assign guard  = s4.mag[23];
    assign sticky = |s4.mag[22:0];
    assign up     = guard && (sticky || kept[0]);
    assign r      = {1'b0, kept} + {24'd0, up};
    assign mant   = r[24] ? r[23:1] : r[22:0];
    assign exp_fin = s4.exp + exp_t'({9'd0, r[24]});

    always_comb
    begin
        if (s4.fast)
            result = s4.res;
        else if (s4.zero)
            result = {s4.zsign, 31'd0};
        else if (s4.denorm)
            // rounding up into the hidden bit promotes to the smallest normal
            result = {s4.sign, 7'd0, r[23], r[22:0]};
        else if (exp_fin >= 10'sd255)
            result = {s4.sign, 8'hFF, 23'd0};
        else
            result = {s4.sign, exp_fin[7:0], mant};
    end

endmodule

`default_nettype wire

>>> hdl/single_precision_fpu_ops.sv
// throughput: one beat per cycle while the response is not stalled, through five
// register stages in turn (prep, add, leading zero count, normalize shift, round
// into the output register); a stalled response holds each full stage with no empty
// stage below it; empty stages still fill
// reset clears all stage valid bits; payload registers are not reset
`default_nettype none

module single_precision_fpu_ops (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spfo_req_if.sink    req,
    spfo_rsp_if.source  rsp
);
    import spfo_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    s1_t  s1_next, s1_reg;
    s2_t  s2_next, s2_reg;
    s3_t  s3_next, s3_reg;
    s4_t  s4_next, s4_reg;
    logic [31:0] res5_next, res5_reg;

    logic [5:0] lz;
    exp_t       lz_e, rsh;

    assign adv5 = !v5_reg || rsp.ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign req.ready  = adv1;
    assign rsp.valid  = v5_reg;
    assign rsp.result = res5_reg;

    spfo_prep u_prep (
        .cmd          (req.cmd),
        .variant      (req.variant),
        .unsigned_sel (req.unsigned_sel),
        .operand_a    (req.operand_a),
        .operand_b    (req.operand_b),
        .s1           (s1_next)
    );

    // stage 2: significand add or subtract
    always_comb
    begin
        s2_next.fast  = s1_reg.fast;
        s2_next.res   = s1_reg.res;
        s2_next.sign  = s1_reg.sign;
        s2_next.zsign = s1_reg.zsign;
        s2_next.exp   = s1_reg.exp;
        if (!s1_reg.do_add)
            s2_next.mag = s1_reg.x;
        else if (s1_reg.eff_sub)
            s2_next.mag = s1_reg.x - s1_reg.y;
        else
            s2_next.mag = s1_reg.x + s1_reg.y;
    end

    // stage 3: leading zero count and shift plan
    always_comb
    begin
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (s2_reg.mag[i])
                lz = 6'(47 - i);
        end
    end

    assign lz_e = exp_t'({4'd0, lz});
    assign rsh  = 10'sd1 - s2_reg.exp;

    always_comb
    begin
        s3_next.fast  = s2_reg.fast;
        s3_next.res   = s2_reg.res;
        s3_next.sign  = s2_reg.sign;
        s3_next.zsign = s2_reg.zsign;
        s3_next.zero  = s2_reg.mag == 48'd0;
        s3_next.mag   = s2_reg.mag;
        s3_next.exp   = s2_reg.exp - lz_e;
        if (s2_reg.exp > lz_e)
        begin
            s3_next.left   = 1'b1;
            s3_next.amt    = lz;
            s3_next.denorm = 1'b0;
        end
        else if (s2_reg.exp >= 10'sd1)
        begin
            // normalizing stops at the minimum exponent
            s3_next.left   = 1'b1;
            s3_next.amt    = 6'(s2_reg.exp - 10'sd1);
            s3_next.denorm = 1'b1;
        end
        else
        begin
            s3_next.left   = 1'b0;
            s3_next.amt    = (rsh > 10'sd63) ? 6'd63 : rsh[5:0];
            s3_next.denorm = 1'b1;
        end
    end

    // stage 4: normalize or denormalize shift, sticky kept in the lsb
    always_comb
    begin
        s4_next.fast   = s3_reg.fast;
        s4_next.res    = s3_reg.res;
        s4_next.sign   = s3_reg.sign;
        s4_next.zsign  = s3_reg.zsign;
        s4_next.zero   = s3_reg.zero;
        s4_next.denorm = s3_reg.denorm;
        s4_next.exp    = s3_reg.exp;
        if (s3_reg.left)
            s4_next.mag = s3_reg.mag << s3_reg.amt;
        else
            s4_next.mag = (s3_reg.mag >> s3_reg.amt) |
                          {47'd0, |(s3_reg.mag & ~({48{1'b1}} << s3_reg.amt))};
    end

    spfo_round u_round (
        .s4     (s4_reg),
        .result (res5_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= req.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= s1_next;
        if (adv2)
            s2_reg <= s2_next;
        if (adv3)
            s3_reg <= s3_next;
        if (adv4)
            s4_reg <= s4_next;
        if (adv5)
            res5_reg <= res5_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> v1_reg)
        else $error("accepted beat did not enter stage one");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !adv4 |=> v3_reg && $stable(s3_reg))
        else $error("stalled stage three lost its beat");

    a_no_raw_nan: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !s4_reg.fast |-> !((res5_next[30:23] == 8'hFF) && (res5_next[22:0] != 23'd0)))
        else $error("rounding path produced a nan");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
        else $error("request stalled with an empty stage");
`endif

endmodule

`default_nettype wire
